@@ rtl/core/agfr_pkg.sv @@
// Shared widths, constants and operation codes of the audio gain fade ramp unit.
package agfr_pkg;

    localparam int OP_W        = 2;
    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 16;
    localparam int OUT_LEVEL_W = 15;
    localparam int FPM_W       = 8;
    localparam int MS_W        = 16;
    localparam int FRAMES_W    = 24;
    localparam int PROD_W      = 32;
    localparam int UNITY_SHIFT = 14;
    localparam int SCALED_W    = PROD_W - UNITY_SHIFT;

    localparam logic [FPM_W-1:0] FPM_RESET = 8'd48;

    typedef enum logic [OP_W-1:0] {
        OP_FRAME = 2'd0,
        OP_START = 2'd1,
        OP_FADE  = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

endpackage

@@ rtl/core/audio_gain_fade_ramp_unit.sv @@
// Top level of the audio gain fade ramp unit: bit-serial volume scaling and linear fade.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------------
//  in      | i_valid / o_stall       | i_operation, i_sample_left/right, i_target_level,
//          |                         | i_fade_kind, i_fade_ms
//  out     | o_valid / i_stall       | o_out_left/right, o_frame_valid, o_track_ended,
//          |                         | o_current_level
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_data (frames per millisecond)
//
// One transaction at a time. A frame during a fade runs through the shared serial divider
// (24 then 32 quotient bits) and serial multiplier (16 product bits), one bit per cycle.
// A frame with no fade waits only on the 16-bit serial scaler; a linear start, fade or
// stop runs the 8-bit serial ramp length multiply.
// Reset is synchronous, active low, and clears all control and ramp state at once.
// A stall holds the output register; the next item is taken but then waits in S_DONE.
module audio_gain_fade_ramp_unit #(
    parameter int unsigned GAIN_LIMIT = 32767
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [agfr_pkg::OP_W-1:0]             i_operation,
    input  logic signed [agfr_pkg::SAMPLE_W-1:0]  i_sample_left,
    input  logic signed [agfr_pkg::SAMPLE_W-1:0]  i_sample_right,
    input  logic [agfr_pkg::LEVEL_W-1:0]          i_target_level,
    input  logic                                  i_fade_kind,
    input  logic [agfr_pkg::MS_W-1:0]             i_fade_ms,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [agfr_pkg::FPM_W-1:0]            i_cfg_data,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [agfr_pkg::SAMPLE_W-1:0]  o_out_left,
    output logic signed [agfr_pkg::SAMPLE_W-1:0]  o_out_right,
    output logic                                  o_frame_valid,
    output logic                                  o_track_ended,
    output logic [agfr_pkg::OUT_LEVEL_W-1:0]      o_current_level
);
    import agfr_pkg::*;

    localparam logic [LEVEL_W-1:0] LIMIT = LEVEL_W'(GAIN_LIMIT);
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int SCNT_W = $clog2(LEVEL_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,     // wait for a transaction
        S_FRAMES,   // ramp length = fade_ms * frames_per_ms
        S_DIV_MS,   // elapsed ms = progress / frames_per_ms
        S_MUL,      // |diff| * ms
        S_DIV_OFF,  // offset = product / ramp_ms
        S_SCALE,    // wait for the sample scaler, then saturate
        S_DONE      // hand the result to the output register
    } t_state;

    t_state r_state;

    // Configuration and fade state
    logic [FPM_W-1:0]    r_fpm;
    logic                r_running;
    logic                r_stopping;
    logic                r_fading;
    logic [LEVEL_W-1:0]  r_gain;
    logic [LEVEL_W-1:0]  r_start;
    logic [LEVEL_W-1:0]  r_end;
    logic [MS_W-1:0]     r_ramp_ms;
    logic [FRAMES_W-1:0] r_ramp_frames;
    logic [FRAMES_W-1:0] r_progress;

    // Shared serial multiplier / divider
    logic [PROD_W-1:0]   r_acc;
    logic [LEVEL_W-1:0]  r_rem;
    logic [LEVEL_W-1:0]  r_dvs;
    logic [MS_W-1:0]     r_mcand;
    logic [MS_W-1:0]     r_mplr;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_neg;

    // Serial sample scaler, both channels side by side
    logic signed [PROD_W-1:0]   r_acc_l;
    logic signed [PROD_W-1:0]   r_acc_r;
    logic signed [SAMPLE_W-1:0] r_smp_l;
    logic signed [SAMPLE_W-1:0] r_smp_r;
    logic [LEVEL_W-1:0]         r_gsh;
    logic [SCNT_W-1:0]          r_scnt;

    // Result of the transaction in flight
    logic signed [SAMPLE_W-1:0] r_res_l;
    logic signed [SAMPLE_W-1:0] r_res_r;
    logic                       r_res_fv;
    logic                       r_res_te;

    // Output register
    logic                         r_ovalid;
    logic signed [SAMPLE_W-1:0]   r_out_l;
    logic signed [SAMPLE_W-1:0]   r_out_r;
    logic                         r_out_fv;
    logic                         r_out_te;
    logic [OUT_LEVEL_W-1:0]       r_out_lvl;

    t_op                 op;
    logic [FPM_W-1:0]    eff_fpm;
    logic [LEVEL_W-1:0]  tgt_clamped;
    logic [LEVEL_W-1:0]  fade_level;
    logic [LEVEL_W-1:0]  base_gain;
    logic [FRAMES_W-1:0] prog_next;
    logic [LEVEL_W:0]    div_sh;
    logic                div_ge;
    logic [LEVEL_W-1:0]  div_rem;
    logic [PROD_W-1:0]   mul_sum;
    logic [LEVEL_W:0]    diff;
    logic [LEVEL_W:0]    diff_neg;
    logic [LEVEL_W-1:0]  diff_mag;
    logic [LEVEL_W-1:0]  off_q;
    logic [LEVEL_W-1:0]  new_level;
    logic signed [PROD_W-1:0] sc_l;
    logic signed [PROD_W-1:0] sc_r;

    // Divide the scaled product by unity gain toward zero, then clip to 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] sat_scaled(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0]   bias;
        logic signed [PROD_W-1:0]   biased;
        logic signed [SCALED_W-1:0] q;
        logic signed [SAMPLE_W-1:0] res;
        bias   = p[PROD_W-1] ? PROD_W'((1 << UNITY_SHIFT) - 1) : '0;
        biased = p + bias;
        q      = biased[PROD_W-1:UNITY_SHIFT];
        if (q[SCALED_W-1:SAMPLE_W-1] == '0 || q[SCALED_W-1:SAMPLE_W-1] == '1) begin
            res = q[SAMPLE_W-1:0];
        end else if (q[SCALED_W-1]) begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return res;
    endfunction

    assign op          = t_op'(i_operation);
    assign eff_fpm     = (r_fpm == '0) ? FPM_W'(1) : r_fpm;
    assign tgt_clamped = (i_target_level > LIMIT) ? LIMIT : i_target_level;
    assign fade_level  = (op == OP_STOP) ? '0 : tgt_clamped;
    // A start drops the level to silence before the fade begins.
    assign base_gain   = (op == OP_START) ? '0 : r_gain;
    assign prog_next   = r_progress + FRAMES_W'(1);

    // Restoring divider step: shift one dividend bit into the remainder.
    assign div_sh  = {r_rem, r_acc[PROD_W-1]};
    assign div_ge  = div_sh >= {1'b0, r_dvs};
    assign div_rem = div_ge ? LEVEL_W'(div_sh - {1'b0, r_dvs}) : div_sh[LEVEL_W-1:0];

    // Shift-add multiplier step, multiplier MSB first.
    assign mul_sum = {r_acc[PROD_W-2:0], 1'b0} + (r_mplr[MS_W-1] ? PROD_W'(r_mcand) : '0);

    assign diff      = {1'b0, r_end} - {1'b0, r_start};
    assign diff_neg  = '0 - diff;
    assign diff_mag  = diff[LEVEL_W] ? diff_neg[LEVEL_W-1:0] : diff[LEVEL_W-1:0];
    // Only the low bits of the offset survive the 16-bit wrap of the level.
    assign off_q     = r_acc[LEVEL_W-1:0];
    assign new_level = r_start + (r_neg ? (LEVEL_W'(0) - off_q) : off_q);

    // Signed sample times unsigned gain, gain MSB first.
    assign sc_l = {r_acc_l[PROD_W-2:0], 1'b0} + (r_gsh[LEVEL_W-1] ? PROD_W'(r_smp_l) : '0);
    assign sc_r = {r_acc_r[PROD_W-2:0], 1'b0} + (r_gsh[LEVEL_W-1] ? PROD_W'(r_smp_r) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fpm         <= FPM_RESET;
            r_running     <= 1'b0;
            r_stopping    <= 1'b0;
            r_fading      <= 1'b0;
            r_gain        <= LEVEL_W'(1 << UNITY_SHIFT);
            r_start       <= '0;
            r_end         <= '0;
            r_ramp_ms     <= '0;
            r_ramp_frames <= '0;
            r_progress    <= '0;
            r_cnt         <= '0;
            r_scnt        <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_fpm <= i_cfg_data;
            end

            // Drain the output register; a load in S_DONE below takes precedence.
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            // Scaler runs alongside the ramp arithmetic.
            if (r_scnt != '0) begin
                r_acc_l <= sc_l;
                r_acc_r <= sc_r;
                r_gsh   <= {r_gsh[LEVEL_W-2:0], 1'b0};
                r_scnt  <= r_scnt - SCNT_W'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_res_fv <= 1'b0;
                        r_res_te <= 1'b0;
                        r_res_l  <= '0;
                        r_res_r  <= '0;
                        r_state  <= S_DONE;
                        case (op)
                            OP_FRAME: begin
                                if (r_running) begin
                                    r_res_fv <= 1'b1;
                                    r_acc_l  <= '0;
                                    r_acc_r  <= '0;
                                    r_smp_l  <= i_sample_left;
                                    r_smp_r  <= i_sample_right;
                                    r_gsh    <= r_gain;
                                    r_scnt   <= SCNT_W'(LEVEL_W);
                                    r_state  <= S_SCALE;
                                    if (r_fading) begin
                                        if (r_progress == r_ramp_frames) begin
                                            // Fade is over: settle, or end the track.
                                            r_fading      <= 1'b0;
                                            r_ramp_ms     <= '0;
                                            r_ramp_frames <= '0;
                                            if (r_stopping) begin
                                                r_start    <= '0;
                                                r_end      <= '0;
                                                r_gain     <= '0;
                                                r_progress <= '0;
                                                r_stopping <= 1'b0;
                                                r_running  <= 1'b0;
                                                r_res_fv   <= 1'b0;
                                                r_res_te   <= 1'b1;
                                                r_scnt     <= '0;
                                                r_state    <= S_DONE;
                                            end else begin
                                                r_start    <= r_end;
                                                r_gain     <= r_end;
                                                r_progress <= FRAMES_W'(1);
                                            end
                                        end else begin
                                            r_progress <= prog_next;
                                            r_acc      <= {prog_next, {(PROD_W-FRAMES_W){1'b0}}};
                                            r_rem      <= '0;
                                            r_dvs      <= LEVEL_W'(eff_fpm);
                                            r_cnt      <= CNT_W'(FRAMES_W);
                                            r_state    <= S_DIV_MS;
                                        end
                                    end
                                end
                            end
                            OP_START, OP_FADE, OP_STOP: begin
                                if (op == OP_START || r_running) begin
                                    if (op == OP_START) begin
                                        r_running  <= 1'b1;
                                        r_stopping <= 1'b0;
                                    end
                                    r_fading   <= i_fade_kind;
                                    r_progress <= '0;
                                    if (i_fade_kind) begin
                                        r_ramp_ms <= i_fade_ms;
                                        r_start   <= base_gain;
                                        r_gain    <= base_gain;
                                        r_end     <= fade_level;
                                        if (op == OP_STOP) begin
                                            r_stopping <= 1'b1;
                                        end
                                        r_acc   <= '0;
                                        r_mcand <= i_fade_ms;
                                        r_mplr  <= {eff_fpm, {(MS_W-FPM_W){1'b0}}};
                                        r_cnt   <= CNT_W'(FPM_W);
                                        r_state <= S_FRAMES;
                                    end else begin
                                        // Jump straight to the target.
                                        r_ramp_ms     <= '0;
                                        r_ramp_frames <= '0;
                                        r_start       <= fade_level;
                                        r_end         <= fade_level;
                                        r_gain        <= fade_level;
                                        if (op == OP_STOP) begin
                                            r_stopping <= 1'b0;
                                            r_running  <= 1'b0;
                                            r_res_te   <= 1'b1;
                                        end
                                    end
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_FRAMES: begin
                    if (r_cnt != '0) begin
                        r_acc  <= mul_sum;
                        r_mplr <= {r_mplr[MS_W-2:0], 1'b0};
                        r_cnt  <= r_cnt - CNT_W'(1);
                    end else begin
                        r_ramp_frames <= r_acc[FRAMES_W-1:0];
                        r_state       <= S_DONE;
                    end
                end

                S_DIV_MS: begin
                    if (r_cnt != '0) begin
                        r_rem <= div_rem;
                        r_acc <= {r_acc[PROD_W-2:0], div_ge};
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else if (r_ramp_ms == '0) begin
                        // Zero-length ramp takes the full difference.
                        r_gain  <= r_end;
                        r_state <= S_SCALE;
                    end else begin
                        r_mplr  <= r_acc[MS_W-1:0];
                        r_mcand <= diff_mag;
                        r_neg   <= diff[LEVEL_W];
                        r_acc   <= '0;
                        r_cnt   <= CNT_W'(MS_W);
                        r_state <= S_MUL;
                    end
                end

                S_MUL: begin
                    if (r_cnt != '0) begin
                        r_acc  <= mul_sum;
                        r_mplr <= {r_mplr[MS_W-2:0], 1'b0};
                        r_cnt  <= r_cnt - CNT_W'(1);
                    end else begin
                        r_rem   <= '0;
                        r_dvs   <= r_ramp_ms;
                        r_cnt   <= CNT_W'(PROD_W);
                        r_state <= S_DIV_OFF;
                    end
                end

                S_DIV_OFF: begin
                    if (r_cnt != '0) begin
                        r_rem <= div_rem;
                        r_acc <= {r_acc[PROD_W-2:0], div_ge};
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else begin
                        r_gain  <= new_level;
                        r_state <= S_SCALE;
                    end
                end

                S_SCALE: begin
                    if (r_scnt == '0) begin
                        r_res_l <= sat_scaled(r_acc_l);
                        r_res_r <= sat_scaled(r_acc_r);
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    // Hold until the output register is free or being emptied.
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid  <= 1'b1;
                        r_out_l   <= r_res_l;
                        r_out_r   <= r_res_r;
                        r_out_fv  <= r_res_fv;
                        r_out_te  <= r_res_te;
                        r_out_lvl <= r_gain[OUT_LEVEL_W-1:0];
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_ovalid;
    assign o_out_left      = r_out_l;
    assign o_out_right     = r_out_r;
    assign o_frame_valid   = r_out_fv;
    assign o_track_ended   = r_out_te;
    assign o_current_level = r_out_lvl;

    // A dropped or ended item never passes a frame on.
    a_end_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_track_ended && o_frame_valid))
        else $error("track end reported together with a passed frame");

    // Samples are silent whenever no frame is passed on.
    a_silent_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_valid) |-> (o_out_left == '0 && o_out_right == '0))
        else $error("non-frame result carries sample data");

    // A pending stop only exists on a running track.
    a_stop_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopping |-> r_running)
        else $error("stopping set on a track that is not running");

    // Scaler must be finished before a result is handed over.
    a_scale_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_scnt == '0))
        else $error("result handed over with the scaler still busy");

endmodule
